// File: rtl/lkv_pkg.sv
// Shared types and constants for the LRU key/value cache.
`default_nettype none
package lkv_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int EFF_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

    typedef enum logic
    {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t               op;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } item_t;

    typedef enum logic
    {
        ENG_LOOKUP = 1'b0,
        ENG_UPDATE = 1'b1
    } eng_state_t;

endpackage
`default_nettype wire

// File: rtl/lkv_front.sv
// Input side: accepts requests and holds them in a short queue for the engine.
`default_nettype none
module lkv_front
(
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          s_tvalid,
    output logic                                               s_tready,
    input  wire logic [lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:0]      s_tdata,  // key, value
    input  wire logic                                          s_tuser,  // operation
    output logic                                               q_valid,
    output lkv_pkg::item_t                                     q_item,
    input  wire logic                                          q_pop
);

    lkv_pkg::item_t                    queue_mem [lkv_pkg::QDEPTH];
    logic [lkv_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [lkv_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [lkv_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                              push;
    logic                              pop;
    lkv_pkg::item_t                    in_item;

    assign s_tready = (count_reg != lkv_pkg::QCNT_W'(lkv_pkg::QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = queue_mem[rd_ptr_reg];

    always_comb
    begin
        in_item.op    = lkv_pkg::op_t'(s_tuser);
        in_item.key   = s_tdata[lkv_pkg::KEY_W-1:0];
        in_item.value = s_tdata[lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:lkv_pkg::KEY_W];
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == lkv_pkg::QPTR_W'(lkv_pkg::QDEPTH - 1)) ? '0
                        : wr_ptr_reg + lkv_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == lkv_pkg::QPTR_W'(lkv_pkg::QDEPTH - 1)) ? '0
                        : rd_ptr_reg + lkv_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + lkv_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - lkv_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// File: rtl/lkv_engine.sv
// Cache engine: parallel key match, LRU rank update, entry store and result register.
`default_nettype none
module lkv_engine
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [lkv_pkg::CNT_W-1:0]       eff_cap,
    input  wire logic                            q_valid,
    input  wire lkv_pkg::item_t                  q_item,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [lkv_pkg::VAL_W-1:0]            m_tdata,
    output logic                                 m_tuser
);

    localparam int N  = lkv_pkg::MAX_ENTRIES;
    localparam int IW = lkv_pkg::IDX_W;

    lkv_pkg::eng_state_t          state_reg, state_next;
    logic [N-1:0]                 valid_reg, valid_next;
    logic [IW-1:0]                rank_reg [N];
    logic [IW-1:0]                rank_next [N];
    logic [lkv_pkg::CNT_W-1:0]    used_reg, used_next;
    logic [lkv_pkg::KEY_W-1:0]    key_mem [N];
    logic [lkv_pkg::VAL_W-1:0]    value_mem [N];

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [lkv_pkg::VAL_W-1:0]    m_tdata_reg;
    logic                         m_tuser_reg;

    lkv_pkg::op_t                 lk_op_reg;
    logic [lkv_pkg::KEY_W-1:0]    lk_key_reg;
    logic [lkv_pkg::VAL_W-1:0]    lk_value_reg;
    logic                         lk_hit_reg;
    logic                         lk_evict_reg;
    logic [IW-1:0]                lk_idx_reg;
    logic [IW-1:0]                lk_rank_reg;
    logic [lkv_pkg::VAL_W-1:0]    lk_rdata_reg;

    logic [N-1:0]                 match;
    logic [N-1:0]                 oldest;
    logic [IW-1:0]                hit_idx;
    logic [IW-1:0]                free_idx;
    logic [IW-1:0]                old_idx;
    logic [lkv_pkg::CNT_W-1:0]    used_m1;
    logic                         hit;
    logic                         evict;
    logic                         out_free;
    logic                         lookup_load;
    logic                         commit;
    logic [lkv_pkg::VAL_W-1:0]    rdata_next;

    assign out_free = !m_tvalid_reg || m_tready;
    assign used_m1  = used_reg - lkv_pkg::CNT_W'(1);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lkv_pkg::ENG_LOOKUP:
            begin
                if (q_valid)
                begin
                    state_next = lkv_pkg::ENG_UPDATE;
                end
            end
            lkv_pkg::ENG_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = lkv_pkg::ENG_LOOKUP;
                end
            end
            default:
            begin
                state_next = lkv_pkg::ENG_LOOKUP;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        lookup_load = 1'b0;
        commit      = 1'b0;
        case (state_reg)
            lkv_pkg::ENG_LOOKUP:
            begin
                lookup_load = q_valid;
            end
            lkv_pkg::ENG_UPDATE:
            begin
                commit = out_free;
            end
            default:
            begin
                lookup_load = 1'b0;
                commit      = 1'b0;
            end
        endcase
    end

    assign q_pop = lookup_load;

    // parallel match, free slot and oldest slot
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        old_idx  = '0;
        for (int i = 0; i < N; i++)
        begin
            match[i]  = valid_reg[i] && (key_mem[i] == q_item.key);
            oldest[i] = valid_reg[i] && (rank_reg[i] == used_m1[IW-1:0]);
        end
        for (int i = N - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = IW'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
            if (oldest[i])
            begin
                old_idx = IW'(i);
            end
        end
        hit   = |match;
        evict = (used_reg >= eff_cap);
    end

    always_ff @(posedge clk)
    begin
        if (lookup_load)
        begin
            lk_op_reg    <= q_item.op;
            lk_key_reg   <= q_item.key;
            lk_value_reg <= q_item.value;
            lk_hit_reg   <= hit;
            lk_evict_reg <= evict;
            lk_idx_reg   <= hit ? hit_idx : (evict ? old_idx : free_idx);
            lk_rank_reg  <= rank_reg[hit_idx];
            lk_rdata_reg <= value_mem[hit_idx];
        end
    end

    // recency and occupancy update
    always_comb
    begin
        valid_next = valid_reg;
        used_next  = used_reg;
        for (int i = 0; i < N; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (commit)
        begin
            if (lk_hit_reg)
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (valid_reg[i] && (IW'(i) != lk_idx_reg) &&
                        (rank_reg[i] < lk_rank_reg))
                    begin
                        rank_next[i] = rank_reg[i] + IW'(1);
                    end
                end
                rank_next[lk_idx_reg] = '0;
            end
            else if (lk_op_reg == lkv_pkg::OP_PUT)
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (valid_reg[i] && (IW'(i) != lk_idx_reg))
                    begin
                        rank_next[i] = rank_reg[i] + IW'(1);
                    end
                end
                rank_next[lk_idx_reg]  = '0;
                valid_next[lk_idx_reg] = 1'b1;
                if (!lk_evict_reg)
                begin
                    used_next = used_reg + lkv_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        if (lk_op_reg == lkv_pkg::OP_GET)
        begin
            rdata_next = lk_hit_reg ? lk_rdata_reg : lkv_pkg::MISS_VALUE;
        end
        else
        begin
            rdata_next = '0;
        end
        m_tvalid_next = m_tvalid_reg;
        if (commit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lkv_pkg::ENG_LOOKUP;
            valid_reg    <= '0;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            used_reg     <= used_next;
            m_tvalid_reg <= m_tvalid_next;
            for (int i = 0; i < N; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            m_tdata_reg <= rdata_next;
            m_tuser_reg <= lk_hit_reg;
            if (lk_op_reg == lkv_pkg::OP_PUT)
            begin
                value_mem[lk_idx_reg] <= lk_value_reg;
                if (!lk_hit_reg)
                begin
                    key_mem[lk_idx_reg] <= lk_key_reg;
                end
            end
        end
    end

    a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == used_reg)
        else $error("entry count differs from valid slots");

    a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
        lookup_load |-> $onehot0(match))
        else $error("key present in more than one slot");

    a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != '0) |-> $onehot(oldest))
        else $error("recency ranks are not a permutation");

    a_put_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && lk_op_reg == lkv_pkg::OP_PUT) |=> valid_reg[$past(lk_idx_reg)])
        else $error("stored slot not valid after put");

endmodule
`default_nettype wire

// File: rtl/lru_key_value_cache.sv
// Top level of the LRU key/value cache: capacity register, request queue and engine.
// A fully associative 16-entry key/value store with least-recently-used replacement.
// Each request is a get or a put on s_tuser (0 = get, 1 = put); each produces exactly
// one response transfer: m_tuser is the hit flag and m_tdata the value (-1 on a get
// miss, 0 for a put). Requests enter a two-deep queue; the engine takes one request at
// a time (a parallel key compare across all entries, then the recency and store update,
// which waits while the result register is full), so it pops no new request before the
// last one is done, owing to that read-modify-write of the recency state. With an idle
// queue, a request passes the queue, the lookup registers and the result register
// before m_tvalid rises. cfg_we writes active_capacity (0 acts as 1, above 16 acts
// as 16); write it only while no request is in flight. Reset clears all entries.
`default_nettype none
module lru_key_value_cache
(
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          cfg_we,
    input  wire logic [lkv_pkg::CAP_W-1:0]                     cfg_wdata,
    input  wire logic                                          s_tvalid,
    output logic                                               s_tready,
    input  wire logic [lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:0]      s_tdata,  // lookup_key, write_value
    input  wire logic                                          s_tuser,  // operation
    output logic                                               m_tvalid,
    input  wire logic                                          m_tready,
    output logic [lkv_pkg::VAL_W-1:0]                          m_tdata,  // read_value
    output logic                                               m_tuser   // hit
);

    logic [lkv_pkg::CAP_W-1:0]   cap_reg, cap_next;
    logic [lkv_pkg::EFF_W-1:0]   cap_ext;
    logic [lkv_pkg::CNT_W-1:0]   eff_cap;
    logic                        q_valid;
    lkv_pkg::item_t              q_item;
    logic                        q_pop;

    always_comb
    begin
        cap_next = cfg_we ? cfg_wdata : cap_reg;
        cap_ext  = lkv_pkg::EFF_W'(cap_reg);
        if (cap_ext == '0)
        begin
            eff_cap = lkv_pkg::CNT_W'(1);
        end
        else if (cap_ext > lkv_pkg::EFF_W'(lkv_pkg::MAX_ENTRIES))
        begin
            eff_cap = lkv_pkg::CNT_W'(lkv_pkg::MAX_ENTRIES);
        end
        else
        begin
            eff_cap = lkv_pkg::CNT_W'(cap_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lkv_pkg::CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    lkv_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    lkv_engine u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .eff_cap  (eff_cap),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

// File: test/cache_response_checker.sv
// Response checker for the LRU key/value cache: predicts each response and compares it.
`timescale 1ns / 100ps
`default_nettype none
module cache_response_checker
(
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      cfg_we,
    input  wire logic [lkv_pkg::CAP_W-1:0]                 cfg_wdata,
    input  wire logic                                      s_tvalid,
    input  wire logic                                      s_tready,
    input  wire logic [lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:0]  s_tdata,   // lookup_key, write_value
    input  wire logic                                      s_tuser,   // operation
    input  wire logic                                      m_tvalid,
    input  wire logic                                      m_tready,
    input  wire logic [lkv_pkg::VAL_W-1:0]                 m_tdata,   // read_value
    input  wire logic                                      m_tuser,   // hit
    output int                                             errors,
    output int                                             outstanding
);

    typedef struct packed
    {
        logic                       hit;
        logic [lkv_pkg::VAL_W-1:0]  value;
    } reply_t;

    reply_t                      reply_q[$];
    int                          mismatch_count;

    logic                        cache_valid[lkv_pkg::MAX_ENTRIES];
    logic [lkv_pkg::KEY_W-1:0]   cache_key[lkv_pkg::MAX_ENTRIES];
    logic [lkv_pkg::VAL_W-1:0]   cache_val[lkv_pkg::MAX_ENTRIES];
    int                          cache_age[lkv_pkg::MAX_ENTRIES];
    int                          cache_fill;
    logic [lkv_pkg::CAP_W-1:0]   cache_limit;

    assign errors = mismatch_count;

    // age every valid entry younger than s, then make s the most recent
    task automatic touch_entry(input int s);
        int r;
        r = cache_age[s];
        for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
            if (cache_valid[i] && i != s && cache_age[i] < r)
                cache_age[i]++;
        cache_age[s] = 0;
    endtask

    task automatic predict_access(input lkv_pkg::op_t op,
                                  input logic [lkv_pkg::KEY_W-1:0] key,
                                  input logic [lkv_pkg::VAL_W-1:0] val,
                                  output reply_t res);
        int  found;
        int  target;
        int  eff;
        int  oldest;
        bit  have;
        found = -1;
        for (int i = lkv_pkg::MAX_ENTRIES - 1; i >= 0; i--)
            if (cache_valid[i] && cache_key[i] == key)
                found = i;
        if (op == lkv_pkg::OP_GET)
        begin
            if (found >= 0)
            begin
                touch_entry(found);
                res.hit   = 1'b1;
                res.value = cache_val[found];
            end
            else
            begin
                res.hit   = 1'b0;
                res.value = lkv_pkg::MISS_VALUE;
            end
            return;
        end
        res.value = '0;
        if (found >= 0)
        begin
            cache_val[found] = val;
            touch_entry(found);
            res.hit = 1'b1;
            return;
        end
        res.hit = 1'b0;
        eff = (cache_limit == 0) ? 1 :
              (cache_limit > lkv_pkg::MAX_ENTRIES) ? lkv_pkg::MAX_ENTRIES : cache_limit;
        have   = 1'b0;
        target = 0;
        oldest = 0;
        if (cache_fill >= eff && cache_fill > 0)
        begin
            for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
                if (cache_valid[i] && (!have || cache_age[i] > oldest))
                begin
                    oldest = cache_age[i];
                    target = i;
                    have   = 1'b1;
                end
            if (have)
            begin
                cache_valid[target] = 1'b0;
                cache_fill--;
            end
        end
        if (!have)
            for (int i = 0; i < lkv_pkg::MAX_ENTRIES && !have; i++)
                if (!cache_valid[i])
                begin
                    target = i;
                    have   = 1'b1;
                end
        if (!have)
            return;
        for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
            if (cache_valid[i])
                cache_age[i]++;
        cache_valid[target] = 1'b1;
        cache_key[target]   = key;
        cache_val[target]   = val;
        cache_age[target]   = 0;
        cache_fill++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            reply_q.delete();
            mismatch_count = 0;
            cache_fill     = 0;
            cache_limit    = lkv_pkg::CAP_RESET;
            for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
            begin
                cache_valid[i] = 1'b0;
                cache_key[i]   = '0;
                cache_val[i]   = '0;
                cache_age[i]   = 0;
            end
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                cache_limit = cfg_wdata;
            if (m_tvalid && m_tready)
            begin
                if (reply_q.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: unexpected response hit=%b value=%h",
                                 $realtime, m_tuser, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (m_tuser !== want.hit || m_tdata !== want.value)
                    begin
                        if (mismatch_count < 10)
                            $display("%0t: mismatch hit exp %b got %b, value exp %h got %h",
                                     $realtime, want.hit, m_tuser, want.value, m_tdata);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_access(lkv_pkg::op_t'(s_tuser), s_tdata[lkv_pkg::KEY_W-1:0],
                               s_tdata[lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:lkv_pkg::KEY_W],
                               want);
                reply_q.insert(reply_q.size(), want);
            end
            outstanding <= reply_q.size();
        end
    end

endmodule
`default_nettype wire

// File: test/testbench.sv
// Stimulus and verdict for the LRU key/value cache testbench.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

    logic                                      clk;
    logic                                      rst_n;
    logic                                      cfg_we;
    logic [lkv_pkg::CAP_W-1:0]                 cfg_wdata;
    logic                                      s_tvalid;
    logic                                      s_tready;
    logic [lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:0]  s_tdata;   // lookup_key, write_value
    logic                                      s_tuser;   // operation
    logic                                      m_tvalid;
    logic                                      m_tready;
    logic [lkv_pkg::VAL_W-1:0]                 m_tdata;   // read_value
    logic                                      m_tuser;   // hit

    int                                        errors;
    int                                        outstanding;
    int                                        accepted_items;
    logic                                      calm;
    logic                                      hold_rx;
    logic [lkv_pkg::KEY_W-1:0]                 key_pool[24];

    lru_key_value_cache DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    cache_response_checker resp_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_rx)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(0, 99) >= 36);
    end

    // long receiver stall so the request queue backs up
    initial
    begin
        hold_rx = 1'b0;
        wait (accepted_items >= 150);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (300) @(posedge clk);
        hold_rx <= 1'b0;
    end

    task automatic send_request(input lkv_pkg::op_t op,
                                input logic [lkv_pkg::KEY_W-1:0] key,
                                input logic [lkv_pkg::VAL_W-1:0] val);
        while (!calm && $urandom_range(0, 99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        accepted_items++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_capacity(input logic [lkv_pkg::CAP_W-1:0] cap);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly keys from a small pool so hits and evictions are common
    task automatic random_traffic(input int count, input int span);
        logic [lkv_pkg::KEY_W-1:0] key;
        lkv_pkg::op_t              op;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 80)
                key = key_pool[$urandom_range(0, span)];
            else
                key = $urandom;
            op = lkv_pkg::op_t'(1'($urandom_range(0, 1)));
            send_request(op, key, $urandom);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        calm           = 1'b0;
        accepted_items = 0;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 24; i++)
            key_pool[i] = $urandom;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty cache, extreme keys and values, key -1 holding value -1
        send_request(lkv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(lkv_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(lkv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(lkv_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000);
        send_request(lkv_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(lkv_pkg::OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(lkv_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(lkv_pkg::OP_PUT, 32'h0000_0000, 32'h1234_5678);
        send_request(lkv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(lkv_pkg::OP_GET, 32'h0000_0005, 32'h0000_0000);
        // fill all sixteen entries, then force an eviction
        for (int i = 0; i < 12; i++)
            send_request(lkv_pkg::OP_PUT, 32'd100 + i, $urandom);
        send_request(lkv_pkg::OP_PUT, 32'd200, 32'hA5A5_5A5A);
        send_request(lkv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);

        // capacity lowered below the fill level
        set_capacity(5'd3);
        random_traffic(60, 8);
        set_capacity(5'd0);
        random_traffic(60, 4);
        set_capacity(5'd31);
        random_traffic(100, 23);
        set_capacity(5'd1);
        random_traffic(80, 3);
        set_capacity(5'd5);
        calm <= 1'b1;
        random_traffic(100, 9);
        calm <= 1'b0;
        set_capacity(5'd16);
        random_traffic(100, 21);
        set_capacity(5'd2);
        random_traffic(100, 6);

        settle();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire

// File: files.f
rtl/lkv_pkg.sv
rtl/lkv_front.sv
rtl/lkv_engine.sv
rtl/lru_key_value_cache.sv
test/cache_response_checker.sv
test/testbench.sv
